>>> src/pmt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pmt_pkg;

    // table geometry
    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // item layout
    localparam int KEY_W  = 24;
    localparam int REC_W  = 96;
    localparam int DATA_W = KEY_W + REC_W;

    // configuration
    localparam int CAP_W  = 7;
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int ADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    typedef enum logic [ADDR_W-3:0] {
        REG_CAPACITY = 1'b0
    } t_reg;

    typedef enum logic {
        OP_ADD  = 1'b0,
        OP_TAKE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        t_status          status;
        logic             take_hit;
        logic             write;
        logic [IDX_W-1:0] slot;
    } t_cam_res;

endpackage

`default_nettype wire

>>> src/pmt_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module pmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                             i_wdata,
    input  logic                                         i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                             o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> src/pmt_cam.sv
`timescale 1ns / 1ps
`default_nettype none

module pmt_cam (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_commit,
    input  pmt_pkg::t_op                i_op,
    input  logic [pmt_pkg::KEY_W-1:0]   i_key,
    input  logic [pmt_pkg::CAP_W-1:0]   i_cap,
    output pmt_pkg::t_cam_res           o_res
);

    import pmt_pkg::*;

    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] n_valid;
    logic [KEY_W-1:0]   r_key [ENTRIES];
    logic [CNT_W-1:0]   r_occ;
    logic [CNT_W-1:0]   n_occ;

    logic [ENTRIES-1:0] match;
    logic [ENTRIES-1:0] free_vec;
    logic [ENTRIES-1:0] free_low;
    logic [ENTRIES-1:0] set_vec;
    logic [ENTRIES-1:0] clr_vec;
    logic [IDX_W-1:0]   match_idx;
    logic [IDX_W-1:0]   free_idx;
    logic               hit;
    logic               room;
    logic [CMP_W-1:0]   cap_lim;

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = r_valid[i] && (r_key[i] == i_key);
        end
    end

    assign hit      = |match;
    assign free_vec = ~r_valid;
    // isolate the lowest free slot
    assign free_low = free_vec & (~free_vec + ENTRIES'(1));

    always_comb begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match[i]) begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_low[i]) begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
    end

    assign cap_lim = (CMP_W'(i_cap) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(i_cap);
    assign room    = (CMP_W'(r_occ) < cap_lim) && (|free_vec);

    always_comb begin
        o_res.status   = ST_DONE;
        o_res.take_hit = 1'b0;
        o_res.write    = 1'b0;
        o_res.slot     = match_idx;
        set_vec        = '0;
        clr_vec        = '0;
        n_occ          = r_occ;
        case (i_op)
            OP_ADD: begin
                if (hit) begin
                    o_res.write = i_commit;
                end else if (room) begin
                    o_res.slot  = free_idx;
                    o_res.write = i_commit;
                    set_vec     = free_low;
                    n_occ       = r_occ + CNT_W'(1);
                end else begin
                    o_res.status = ST_FULL;
                end
            end
            OP_TAKE: begin
                if (hit) begin
                    o_res.take_hit = 1'b1;
                    clr_vec        = match;
                    n_occ          = r_occ - CNT_W'(1);
                end else begin
                    o_res.status = ST_MISS;
                end
            end
            default: begin
                o_res.status = ST_MISS;
            end
        endcase
        n_valid = (r_valid | set_vec) & ~clr_vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
        end else if (i_commit) begin
            r_valid <= n_valid;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_commit && set_vec[i]) begin
                r_key[i] <= i_key;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/pending_request_match_table.sv
// Pending request table: up to 64 outstanding requests keyed by transaction
// and unit. An add word stores or overwrites the record for its key, or
// reports table full once occupancy reaches capacity_in_use (APB register at
// address 0, reset 64, values above 64 act as 64). A take word returns the
// stored record and frees its entry, or reports key not found with zero data.
// One word is taken every cycle unless the master side stalls; each word is
// held in the input register, looked up combinationally against all keys
// held in flip-flops, and its result is registered together with the
// registered read of the record RAM. Entry valid bits are flip-flops cleared
// by reset, so the table is usable straight out of reset.
`timescale 1ns / 1ps
`default_nettype none

module pending_request_match_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // transaction, unit, start_address, register_count, time_stamp
    input  logic [pmt_pkg::DATA_W-1:0]     s_axis_tdata,
    // op
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // got_transaction, got_unit, got_start_address, got_register_count,
    // got_time_stamp
    output logic [pmt_pkg::DATA_W-1:0]     m_axis_tdata,
    // status
    output logic [1:0]                     m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmt_pkg::ADDR_W-1:0]     paddr,
    input  logic [pmt_pkg::PDATA_W-1:0]    pwdata,
    output logic [pmt_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    import pmt_pkg::*;

    logic              r_in_valid;
    t_op               r_in_op;
    logic [DATA_W-1:0] r_in_data;
    logic              r_out_valid;
    t_status           r_out_status;
    logic              r_out_hit;
    logic [KEY_W-1:0]  r_out_key;
    logic [CAP_W-1:0]  r_cap;

    logic              out_ready;
    logic              commit;
    logic              cfg_wr;
    t_cam_res          cam_res;
    logic [REC_W-1:0]  ram_rdata;

    assign out_ready     = !r_out_valid || m_axis_tready;
    assign commit        = r_in_valid && out_ready;
    assign s_axis_tready = !r_in_valid || out_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[ADDR_W-1:2] == REG_CAPACITY);
    assign prdata = (paddr[ADDR_W-1:2] == REG_CAPACITY) ? PDATA_W'(r_cap) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_ready) begin
                r_out_valid <= r_in_valid;
            end
            if (cfg_wr) begin
                r_cap <= pwdata[CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_op   <= t_op'(s_axis_tuser);
            r_in_data <= s_axis_tdata;
        end
        if (commit) begin
            r_out_status <= cam_res.status;
            r_out_hit    <= cam_res.take_hit;
            r_out_key    <= r_in_data[KEY_W-1:0];
        end
    end

    pmt_cam u_cam (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_commit (commit),
        .i_op     (r_in_op),
        .i_key    (r_in_data[KEY_W-1:0]),
        .i_cap    (r_cap),
        .o_res    (cam_res)
    );

    // hold the read word while the result is stalled
    pmt_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (cam_res.write),
        .i_waddr (cam_res.slot),
        .i_wdata (r_in_data[DATA_W-1:KEY_W]),
        .i_re    (commit),
        .i_raddr (cam_res.slot),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = r_out_hit ? {ram_rdata, r_out_key} : '0;

endmodule

`default_nettype wire

>>> src/pmt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module pmt_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [pmt_pkg::DATA_W-1:0]     s_axis_tdata,
    input  logic                           s_axis_tuser,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [pmt_pkg::DATA_W-1:0]     m_axis_tdata,
    input  logic [1:0]                     m_axis_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pmt_pkg::ADDR_W-1:0]     paddr,
    input  logic [pmt_pkg::PDATA_W-1:0]    pwdata,
    input  logic [pmt_pkg::PDATA_W-1:0]    prdata,
    input  logic                           pready
);

    import pmt_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // full and not-found results carry no record
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_DONE) |-> m_axis_tdata == '0)
        else $error("non-zero record on a failed request");

    // input back-pressure only when a result is waiting
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with no waiting result");

    // a capacity write reads back
    a_cap_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite && pready && (paddr == '0) ##1 (paddr == '0) |->
            prdata == PDATA_W'($past(pwdata[CAP_W-1:0])))
        else $error("capacity register did not take the written value");

endmodule

bind pending_request_match_table pmt_checker u_pmt_checker (.*);

`default_nettype wire
